FILE: rtl/core/ppmrb_pkg.sv
// ----------------------------------------------------------------------------
// ppmrb_pkg
// Types, constants and the arctangent table of the polar range binning block.
// ----------------------------------------------------------------------------
package ppmrb_pkg;

  localparam int ANGLE_BINS   = 360;
  localparam int BIN_W        = $clog2(ANGLE_BINS);
  localparam int SEL_W        = 9;
  localparam int COORD_W      = 20;
  localparam int RANGE_W      = 18;
  localparam int GAIN_W       = 16;
  localparam int PROD_W       = COORD_W + GAIN_W;
  localparam int LAT_W        = PROD_W - 8;
  localparam int RAD_W        = 2 * LAT_W;
  localparam int ROOT_W       = RAD_W / 2;
  localparam int CORDIC_W     = 48;
  localparam int ANGLE_W      = 34;
  localparam int ROUNDS       = 20;
  localparam int RND_W        = $clog2(ROUNDS + 1);
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 20;

  localparam logic [RANGE_W-1:0] NO_RETURN = '1;

  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATERAL_GAIN = 3'd4;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] pos_lateral;
    logic signed [COORD_W-1:0] pos_height;
    logic signed [COORD_W-1:0] pos_forward;
    logic [SEL_W-1:0]          bin_select;
  } item_t;

  typedef struct packed {
    logic [RANGE_W-1:0] bin_range;
    logic               has_return;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_word_t;

  typedef struct packed {
    logic               valid;
    logic [RANGE_W-1:0] dist_mm;
  } bin_word_t;

  typedef struct packed {
    logic             we;
    logic [BIN_W-1:0] waddr;
    bin_word_t        wdata;
    logic             re;
    logic [BIN_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SQR,
    ST_START,
    ST_RUN,
    ST_CHECK,
    ST_UPDATE,
    ST_READOUT
  } state_e;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [RND_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051D;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2E;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;
      5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;
      5'd19: v = 32'h00000517;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/ppmrb_item_if.sv
// ----------------------------------------------------------------------------
// ppmrb_item_if
// Valid/ready channel that carries one input word.
// ----------------------------------------------------------------------------
interface ppmrb_item_if import ppmrb_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/ppmrb_result_if.sv
// ----------------------------------------------------------------------------
// ppmrb_result_if
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface ppmrb_result_if import ppmrb_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/ppmrb_cfg_if.sv
// ----------------------------------------------------------------------------
// ppmrb_cfg_if
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ppmrb_cfg_if import ppmrb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/ppmrb_bin_mem.sv
// ----------------------------------------------------------------------------
// ppmrb_bin_mem
// Bin store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module ppmrb_bin_mem import ppmrb_pkg::*; (
  input  logic      clk_i,
  input  mem_req_t  req_i,
  output bin_word_t rdata_o
);

  bin_word_t mem [ANGLE_BINS];
  bin_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ppmrb_sqrt.sv
// ----------------------------------------------------------------------------
// ppmrb_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ppmrb_sqrt import ppmrb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W-1:0]  cand;
  logic [REM_W-1:0]  trial;

  assign cand  = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (cand >= trial) begin
        rem_q  <= cand - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= cand;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

FILE: rtl/core/ppmrb_cordic.sv
// ----------------------------------------------------------------------------
// ppmrb_cordic
// Iterative CORDIC vectoring, one round per cycle, then the bin index.
// ----------------------------------------------------------------------------
module ppmrb_cordic import ppmrb_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [LAT_W-1:0]   y_i,
  output logic                      busy_o,
  output logic [BIN_W-1:0]          bin_o
);

  localparam int MUL_W = 33 + BIN_W + 2;

  logic                       busy_q;
  logic [RND_W-1:0]           rnd_q;
  logic signed [CORDIC_W-1:0] x_q, y_q;
  logic signed [ANGLE_W-1:0]  z_q;
  logic [BIN_W-1:0]           bin_q;

  logic signed [CORDIC_W-1:0] x_ext, y_ext, dx, dy;
  logic signed [ANGLE_W-1:0]  z_init, tab, u;
  logic [32:0]                uc;
  logic [MUL_W-1:0]           prod;
  logic [MUL_W-33:0]          bq;
  logic [BIN_W-1:0]           bin_d;

  always_comb begin
    x_ext  = CORDIC_W'(x_i);
    y_ext  = CORDIC_W'(y_i);
    z_init = '0;
    // Left half plane: turn by half a turn first.
    if (x_i < 0) begin
      z_init = (y_i < 0) ? -ANGLE_W'(64'sh80000000) : ANGLE_W'(64'sh80000000);
      x_ext  = -x_ext;
      y_ext  = -y_ext;
    end
    x_ext = x_ext <<< 16;
    y_ext = y_ext <<< 16;
  end

  assign dx  = y_q >>> rnd_q;
  assign dy  = x_q >>> rnd_q;
  assign tab = ANGLE_W'(atan_turn(rnd_q));

  always_comb begin
    u = z_q + ANGLE_W'(64'sh80000000);
    if (u < 0) begin
      uc = '0;
    end else if (u > ANGLE_W'(64'sh100000000)) begin
      uc = 33'h100000000;
    end else begin
      uc = u[32:0];
    end
    prod = MUL_W'(uc) * MUL_W'(ANGLE_BINS);
    bq   = prod[MUL_W-1:32];
    if (bq >= (MUL_W-32)'(ANGLE_BINS)) begin
      bin_d = BIN_W'(ANGLE_BINS - 1);
    end else begin
      bin_d = bq[BIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      rnd_q  <= '0;
    end else if (busy_q) begin
      if (rnd_q == RND_W'(ROUNDS)) begin
        busy_q <= 1'b0;
      end else begin
        rnd_q <= rnd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_ext;
      y_q <= y_ext;
      z_q <= z_init;
    end else if (busy_q) begin
      if (rnd_q == RND_W'(ROUNDS)) begin
        bin_q <= bin_d;
      end else if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + tab;
      end else if (y_q < 0) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - tab;
      end
    end
  end

  assign busy_o = busy_q;
  assign bin_o  = bin_q;

endmodule

FILE: rtl/core/point_to_polar_min_range_bins.sv
// ----------------------------------------------------------------------------
// point_to_polar_min_range_bins
// Folds 3D points into a scan that keeps the nearest range per angular bin.
// ----------------------------------------------------------------------------
//  Channel   Dir  Word                          Result
//  in_i      in   operation, coordinates, bin   read: one word; add: none
//  out_o     out  bin_range, has_return         -
//  cfg_i     in   register index, data          -
//
// An add word in the height band holds the input off through the multiply
// states ST_MUL and ST_SQR, the start state, the bit-serial square root
// (the CORDIC finishes beside it), then a read and a write of the bin memory,
// or up to ST_CHECK when the range is out of limits. An add word outside the
// band is dropped as it is accepted. After reset a clearing pass marks every
// bin as no-return first; a read word waits while the output is full.
// ----------------------------------------------------------------------------
module point_to_polar_min_range_bins import ppmrb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppmrb_item_if.sink  in_i,
  ppmrb_result_if.source out_o,
  ppmrb_cfg_if.sink   cfg_i
);

  state_e state_q, state_d;

  logic signed [COORD_W-1:0] height_min_q, height_max_q;
  logic [RANGE_W-1:0]        range_min_q, range_max_q;
  logic [GAIN_W-1:0]         gain_q;

  item_t                     item_q;
  logic                      sel_ok_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [2*COORD_W-1:0]      xx_q;
  logic [RAD_W-1:0]          yy_q;
  logic signed [LAT_W-1:0]   y_q, yv;
  logic [BIN_W-1:0]          clr_q;
  logic                      out_valid_q;
  result_t                   out_q;

  logic                      accept, sel_ok, h_ok, out_free, r_ok;
  logic                      sq_start, sq_busy, co_busy;
  logic [ROOT_W-1:0]         root;
  logic [BIN_W-1:0]          bin;
  mem_req_t                  req;
  bin_word_t                 rdata;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign sel_ok      = 32'(in_i.data.bin_select) < 32'(ANGLE_BINS);
  assign h_ok        = (in_i.data.pos_height >= height_min_q) &&
                       (in_i.data.pos_height <= height_max_q);
  assign out_free    = !out_valid_q || out_o.ready;
  assign yv          = prod_q[PROD_W-1:8];
  assign r_ok        = (root >= ROOT_W'(range_min_q)) && (root <= ROOT_W'(range_max_q));
  assign sq_start    = (state_q == ST_START);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_min_q <= COORD_W'(30);
      height_max_q <= COORD_W'(1500);
      range_min_q  <= RANGE_W'(100);
      range_max_q  <= RANGE_W'(200000);
      gain_q       <= GAIN_W'(768);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_HEIGHT_MIN:   height_min_q <= cfg_i.data;
        REG_HEIGHT_MAX:   height_max_q <= cfg_i.data;
        REG_RANGE_MIN:    range_min_q  <= cfg_i.data[RANGE_W-1:0];
        REG_RANGE_MAX:    range_max_q  <= cfg_i.data[RANGE_W-1:0];
        REG_LATERAL_GAIN: gain_q       <= cfg_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_READOUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q   <= in_i.data;
      sel_ok_q <= sel_ok;
    end
    if (state_q == ST_MUL) begin
      prod_q <= item_q.pos_lateral * $signed({1'b0, gain_q});
    end
    if (state_q == ST_SQR) begin
      xx_q <= item_q.pos_forward * item_q.pos_forward;
      yy_q <= yv * yv;
      y_q  <= yv;
    end
    if (state_q == ST_READOUT && out_free) begin
      out_q.bin_range  <= (sel_ok_q && rdata.valid) ? rdata.dist_mm : NO_RETURN;
      out_q.has_return <= sel_ok_q && rdata.valid;
    end
  end

  always_comb begin
    state_d   = state_q;
    req       = '0;
    req.waddr = clr_q;
    req.wdata = '{valid: 1'b0, dist_mm: NO_RETURN};
    case (state_q)
      ST_CLEAR: begin
        req.we = 1'b1;
        if (clr_q == BIN_W'(ANGLE_BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_i.data.operation == OP_READ) begin
            req.re    = sel_ok;
            req.raddr = BIN_W'(in_i.data.bin_select);
            state_d   = ST_READOUT;
          end else if (h_ok) begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL:   state_d = ST_SQR;
      ST_SQR:   state_d = ST_START;
      ST_START: state_d = ST_RUN;
      ST_RUN: begin
        if (!sq_busy && !co_busy) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (r_ok) begin
          req.re    = 1'b1;
          req.raddr = bin;
          state_d   = ST_UPDATE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_UPDATE: begin
        req.waddr = bin;
        req.wdata = '{valid: 1'b1, dist_mm: root[RANGE_W-1:0]};
        req.we    = !rdata.valid || (root[RANGE_W-1:0] < rdata.dist_mm);
        state_d   = ST_IDLE;
      end
      ST_READOUT: begin
        if (out_free) begin
          // Reading a bin clears it to no-return.
          req.we    = sel_ok_q;
          req.waddr = BIN_W'(item_q.bin_select);
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  ppmrb_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (RAD_W'(xx_q) + yy_q),
    .busy_o     (sq_busy),
    .root_o     (root)
  );

  ppmrb_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (item_q.pos_forward),
    .y_i     (y_q),
    .busy_o  (co_busy),
    .bin_o   (bin)
  );

  ppmrb_bin_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives add and read words into the polar range binning block, checks every
// read result against a predictor of the nearest range per angular bin, and
// walks the height band, range limits and lateral gain through several
// settings between drained phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ppmrb_pkg::*;

  typedef enum logic [1:0] {E_WORD, E_REG, E_DRAIN} entry_kind_e;

  typedef struct {
    entry_kind_e          kind;
    item_t                word;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DATA_W-1:0] val;
  } entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppmrb_item_if   in_if();
  ppmrb_result_if out_if();
  ppmrb_cfg_if    cfg_if();

  point_to_polar_min_range_bins uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic signed [COORD_W-1:0] band_lo = 20'sd30;
  logic signed [COORD_W-1:0] band_hi = 20'sd1500;
  logic [RANGE_W-1:0]        near_lim = 18'd100;
  logic [RANGE_W-1:0]        far_lim = 18'd200000;
  logic [GAIN_W-1:0]         lat_gain = 16'd768;
  logic [RANGE_W-1:0]        bin_dist [ANGLE_BINS];
  logic                      bin_hit [ANGLE_BINS];

  entry_t  stim_q[$];
  result_t scan_q[$];
  int      errors = 0;
  int      quiet = 0;
  bit      in_took = 1'b0;
  bit      cfg_took = 1'b0;
  bit      calm = 1'b0;

  initial begin
    for (int i = 0; i < ANGLE_BINS; i++) begin
      bin_dist[i] = NO_RETURN;
      bin_hit[i] = 1'b0;
    end
  end

  task automatic report(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC on the angle in units of 2^-32 turn, then binning.
  function automatic int angle_to_bin(input longint x, input longint y);
    longint z, dx, dy, u, b;
    z = 0;
    if (x < 0) begin
      z = (y < 0) ? -64'sh80000000 : 64'sh80000000;
      x = -x;
      y = -y;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < ROUNDS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += longint'(atan_turn(i[RND_W-1:0]));
      end else if (y < 0) begin
        x -= dx;
        y += dy;
        z -= longint'(atan_turn(i[RND_W-1:0]));
      end
    end
    u = z + 64'sh80000000;
    if (u < 0) u = 0;
    if (u > 64'sh100000000) u = 64'sh100000000;
    b = (u * ANGLE_BINS) >>> 32;
    if (b >= ANGLE_BINS) b = ANGLE_BINS - 1;
    return int'(b);
  endfunction

  function automatic void fold_word(input item_t w);
    result_t r;
    longint  x, y, rng;
    int      b;
    if (w.operation == OP_READ) begin
      if (w.bin_select < ANGLE_BINS) begin
        r.bin_range = bin_hit[w.bin_select] ? bin_dist[w.bin_select] : NO_RETURN;
        r.has_return = bin_hit[w.bin_select];
        bin_dist[w.bin_select] = NO_RETURN;
        bin_hit[w.bin_select] = 1'b0;
      end else begin
        r.bin_range = NO_RETURN;
        r.has_return = 1'b0;
      end
      scan_q.push_back(r);
    end else begin
      if (w.pos_height < band_lo || w.pos_height > band_hi) return;
      y = (longint'(w.pos_lateral) * longint'(lat_gain)) >>> 8;
      x = longint'(w.pos_forward);
      rng = longint'(int_sqrt(longint'(x * x + y * y)));
      if (rng < longint'(near_lim) || rng > longint'(far_lim)) return;
      b = angle_to_bin(x, y);
      if (!bin_hit[b] || rng < longint'(bin_dist[b])) begin
        bin_dist[b] = rng[RANGE_W-1:0];
        bin_hit[b] = 1'b1;
      end
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_HEIGHT_MIN:   band_lo = val;
      REG_HEIGHT_MAX:   band_hi = val;
      REG_RANGE_MIN:    near_lim = val[RANGE_W-1:0];
      REG_RANGE_MAX:    far_lim = val[RANGE_W-1:0];
      REG_LATERAL_GAIN: lat_gain = val[GAIN_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Monitor: everything is sampled at the rising edge.
  always @(posedge clk_i) begin
    in_took <= rst_ni && in_if.valid && in_if.ready;
    cfg_took <= rst_ni && cfg_if.valid && cfg_if.ready;
    if (rst_ni) begin
      quiet <= (in_if.valid && in_if.ready) ? 0 : quiet + 1;
      if (in_if.valid && in_if.ready) fold_word(in_if.data);
      if (cfg_if.valid && cfg_if.ready) apply_reg(cfg_if.index, cfg_if.data);
      if (out_if.valid && out_if.ready) begin
        if (scan_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          if (out_if.data.bin_range !== scan_q[0].bin_range)
            report($sformatf("bin_range %0d, expected %0d",
                             out_if.data.bin_range, scan_q[0].bin_range));
          if (out_if.data.has_return !== scan_q[0].has_return)
            report($sformatf("has_return %0b, expected %0b",
                             out_if.data.has_return, scan_q[0].has_return));
          void'(scan_q.pop_front());
        end
      end
    end
  end

  // Driver: inputs change at the falling edge.
  int gap = 0;
  int rgap = 0;
  always @(negedge clk_i) begin
    logic  v, cv, rdy;
    item_t d;
    logic [CFG_IDX_W-1:0] ci;
    logic [CFG_DATA_W-1:0] cd;
    v = in_if.valid;
    cv = cfg_if.valid;
    d = in_if.data;
    ci = cfg_if.index;
    cd = cfg_if.data;
    if (rgap > 0) begin
      rgap <= rgap - 1;
      rdy = 1'b0;
    end else begin
      rgap <= gap_len();
      rdy = 1'b1;
    end
    if (rst_ni) begin
      if (v && in_took) v = 1'b0;
      if (cv && cfg_took) cv = 1'b0;
      if (!v && !cv) begin
        if (gap > 0) begin
          gap <= gap - 1;
        end else if (stim_q.size() != 0) begin
          if (stim_q[0].kind == E_WORD) begin
            d = stim_q[0].word;
            v = 1'b1;
            void'(stim_q.pop_front());
            gap <= gap_len();
          end else if (scan_q.size() == 0 && quiet >= 60 && !in_took) begin
            if (stim_q[0].kind == E_REG) begin
              ci = stim_q[0].idx;
              cd = stim_q[0].val;
              cv = 1'b1;
            end else begin
              calm <= ($urandom_range(0, 3) == 0);
            end
            void'(stim_q.pop_front());
          end
        end
      end
    end
    in_if.valid <= v;
    in_if.data <= d;
    cfg_if.valid <= cv;
    cfg_if.index <= ci;
    cfg_if.data <= cd;
    out_if.ready <= rdy;
  end

  task automatic push_word(input logic op, input int lat, input int hgt,
                           input int fwd, input int sel);
    entry_t e;
    e.kind = E_WORD;
    e.word.operation = op;
    e.word.pos_lateral = lat[COORD_W-1:0];
    e.word.pos_height = hgt[COORD_W-1:0];
    e.word.pos_forward = fwd[COORD_W-1:0];
    e.word.bin_select = sel[SEL_W-1:0];
    e.idx = '0;
    e.val = '0;
    stim_q.push_back(e);
  endtask

  task automatic push_regs(input int lo, input int hi, input int rmin,
                           input int rmax, input int gain);
    entry_t e;
    int     vals [5];
    e.kind = E_DRAIN;
    e.word = '0;
    e.idx = '0;
    e.val = '0;
    stim_q.push_back(e);
    vals = '{lo, hi, rmin, rmax, gain};
    e.kind = E_REG;
    for (int i = 0; i < 5; i++) begin
      e.idx = i[CFG_IDX_W-1:0];
      e.val = vals[i][CFG_DATA_W-1:0];
      stim_q.push_back(e);
    end
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 2000) - 1000;
      1: return $urandom_range(0, 60000) - 30000;
      2: return $signed($urandom_range(0, 20'hFFFFF) << 12) >>> 12;
      default: return $urandom_range(0, 200000) - 100000;
    endcase
  endfunction

  task automatic push_random(input int count, input int lo, input int hi);
    int h;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 30) begin
        push_word(OP_READ, rand_coord(), rand_coord(), rand_coord(),
                  ($urandom_range(0, 19) == 0) ? $urandom_range(360, 511)
                                               : $urandom_range(0, 359));
      end else begin
        if (lo <= hi && $urandom_range(0, 99) < 80)
          h = lo + int'($urandom_range(0, 32'(hi - lo)));
        else
          h = rand_coord();
        push_word(OP_ADD, rand_coord(), h, rand_coord(), $urandom_range(0, 511));
      end
    end
  endtask

  initial begin
    int lo, hi;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;

    // Reset settings: empty reads, out-of-range bins, the angle of +pi.
    push_word(OP_READ, 0, 0, 0, 0);
    push_word(OP_READ, 0, 0, 0, 359);
    push_word(OP_READ, 0, 0, 0, 360);
    push_word(OP_READ, -1, -1, -1, 511);
    push_word(OP_ADD, 0, 100, -1000, 0);
    push_word(OP_ADD, 0, 100, -900, 0);
    push_word(OP_READ, 0, 0, 0, 359);
    push_word(OP_READ, 0, 0, 0, 359);
    push_word(OP_ADD, -524288, 100, 524287, 0);
    push_word(OP_ADD, 524287, -524288, -524288, 0);
    push_word(OP_ADD, 100, 524287, 100, 0);
    push_word(OP_ADD, 0, 30, 100, 0);
    push_word(OP_ADD, 0, 1500, 99, 0);
    push_word(OP_READ, 0, 0, 0, 180);

    // Widest settings: origin point, ranges beyond 18 bits, full-scale range.
    push_regs(-524288, 524287, 0, 262143, 256);
    push_word(OP_ADD, 0, 0, 0, 0);
    push_word(OP_READ, 0, 0, 0, 180);
    push_word(OP_ADD, 0, 0, -262143, 0);
    push_word(OP_READ, 0, 0, 0, 359);
    push_word(OP_ADD, 524287, 0, 524287, 0);
    push_word(OP_ADD, 0, 0, 2000, 0);
    push_word(OP_READ, 0, 0, 0, 180);
    push_random(300, -524288, 524287);

    // Empty height band, then inverted range limits.
    push_regs(500, 400, 0, 262142, 768);
    push_random(80, 400, 500);
    push_regs(-1000, 1000, 5000, 4000, 768);
    push_random(80, -1000, 1000);

    // Gain extremes.
    push_regs(-100, 100, 0, 262142, 0);
    push_random(200, -100, 100);
    push_regs(-524288, 524287, 1, 262142, 65535);
    push_random(250, -524288, 524287);

    push_regs(30, 1500, 100, 200000, 768);
    push_random(400, 30, 1500);

    for (int p = 0; p < 3; p++) begin
      lo = $urandom_range(0, 4000) - 2000;
      hi = lo + $urandom_range(0, 4000);
      push_regs(lo, hi, $urandom_range(0, 3000), $urandom_range(50000, 262142),
                $urandom_range(0, 65535));
      push_random(200, lo, hi);
    end

    #40 rst_ni = 1'b1;

    while (stim_q.size() != 0 || in_if.valid || scan_q.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0 && scan_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ppmrb_pkg.sv
rtl/core/ppmrb_item_if.sv
rtl/core/ppmrb_result_if.sv
rtl/core/ppmrb_cfg_if.sv
rtl/core/ppmrb_bin_mem.sv
rtl/core/ppmrb_sqrt.sv
rtl/core/ppmrb_cordic.sv
rtl/core/point_to_polar_min_range_bins.sv
test/testbench.sv
